// ===== hdl/ogh_pkg.sv =====
package ogh_pkg;

  localparam int ANGLE_W = 16;
  localparam int COORD_W = 16;
  localparam int POINT_W = 17;
  localparam int TRIG_W  = 17;
  localparam int CONF_W  = 8;

  localparam logic [2:0] REG_ANGLE_START = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] REG_MIN_RANGE   = 3'd2;
  localparam logic [2:0] REG_MAX_RANGE   = 3'd3;
  localparam logic [2:0] REG_CELLS_PER_M = 3'd4;
  localparam logic [2:0] REG_HIT_INC     = 3'd5;
  localparam logic [2:0] REG_OCC_THRESH  = 3'd6;
  localparam logic [2:0] REG_CONF_CAP    = 3'd7;

  // One classified beam as it waits between the front end and the back end.
  typedef struct packed {
    logic                       used;
    logic signed [COORD_W-1:0]  robot_x;
    logic signed [COORD_W-1:0]  robot_z;
    logic        [ANGLE_W-1:0]  angle;
    logic        [15:0]         beam_range;
  } beam_t;

  // Configuration fields used by the back end.
  typedef struct packed {
    logic [9:0] cells_per_meter;
    logic [5:0] hit_step;
    logic [7:0] occ_limit;
    logic [7:0] confidence_cap;
  } back_cfg_t;

endpackage

// ===== hdl/occupancy_grid_hit_update_unit.sv =====
// Occupancy grid hit counter for a lidar beam stream.
// Slave channel (s_axis_*) takes one beam per item: pose, beam index, range
// and a no-return flag. Master channel (m_axis_*) returns exactly one result
// item per beam, in order: whether it was used, the grid cell, the hit point,
// the cell confidence after the update and a newly-occupied flag.
// The cfg_* channel writes the eight configuration registers by index; it
// is always ready and should only be used while no beam is in flight.
// A front end classifies each beam and forms its angle, then parks it in a
// two-entry queue, so new beams are taken while the back end still works.
// The back end runs one beam at a time: a used beam passes its sine
// pipeline, multiplies and the single read-modify-write port of the cell
// store, while a skipped beam goes straight to the output register.
// After reset the back end clears the 65536-entry (GRID_SIDE squared)
// store, one cell per cycle; beams queue but are not processed until then.
// When the receiver stalls, the result is held in the output register and
// the front end keeps accepting until its queue is full.
module occupancy_grid_hit_update_unit
  import ogh_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: robot_x[15:0], robot_z[31:16], heading[47:32],
  // beam_index[57:48], beam_range[73:58], no_return[74], zero fill.
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  // Fields from bit 0: used[0], cell_x[8:1], cell_y[16:9], point_x[33:17],
  // point_z[50:34], confidence[58:51], newly_occupied[59], zero fill.
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] angle_start;
  logic [15:0] angle_step, min_range, max_range;
  back_cfg_t bcfg;
  logic q_valid, q_ready, busy;
  beam_t q_beam;
  logic [59:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= -16'sd16384;
      angle_step <= 16'd128;
      min_range <= 16'd0;
      max_range <= 16'hffff;
      bcfg.cells_per_meter <= 10'd100;
      bcfg.hit_step <= 6'd5;
      bcfg.occ_limit <= 8'd20;
      bcfg.confidence_cap <= 8'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_START: angle_start <= cfg_data;
        REG_ANGLE_STEP:  angle_step <= cfg_data;
        REG_MIN_RANGE:   min_range <= cfg_data;
        REG_MAX_RANGE:   max_range <= cfg_data;
        REG_CELLS_PER_M: bcfg.cells_per_meter <= cfg_data[9:0];
        REG_HIT_INC:     bcfg.hit_step <= cfg_data[5:0];
        REG_OCC_THRESH:  bcfg.occ_limit <= cfg_data[7:0];
        REG_CONF_CAP:    bcfg.confidence_cap <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ogh_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .robot_x(s_axis_tdata[15:0]), .robot_z(s_axis_tdata[31:16]),
    .heading(s_axis_tdata[47:32]), .beam_index(s_axis_tdata[57:48]),
    .beam_range(s_axis_tdata[73:58]), .no_return(s_axis_tdata[74]),
    .angle_start(angle_start), .angle_step(angle_step),
    .min_range(min_range), .max_range(max_range),
    .q_valid(q_valid), .q_ready(q_ready), .q_beam(q_beam)
  );

  ogh_back #(.GRID_SIDE(GRID_SIDE)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_beam(q_beam), .cfg(bcfg),
    .busy(busy), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(res)
  );

  assign m_axis_tdata = {4'd0, res};

`ifndef NO_ASSERTIONS
  // A skipped beam must come out with every field zero.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[63:1] == '0)
    else $error("skipped beam carries nonzero fields");
  // A result never appears while the back end has nothing to do.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> busy)
    else $error("result without work in flight");
  // A newly occupied cell implies a used beam.
  a_fresh_used: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[59] |-> m_axis_tdata[0])
    else $error("fresh mark on skipped beam");
`endif

endmodule

// ===== hdl/ogh_sine.sv =====
module ogh_sine
  import ogh_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [ANGLE_W-1:0]       angle,
  output logic signed [TRIG_W-1:0] sine
);

  // Polynomial sine over a chain of registered stages, with four multiplies.
  logic [1:0]  q0, q1, q2, q3;
  logic [14:0] z0, z1, z2r, z3;
  logic [14:0] zsq1, zsq2;
  logic [15:0] v3;
  logic [14:0] zz;
  logic [29:0] sq_p;
  logic [26:0] t_p;
  logic [11:0] t2;
  logic [14:0] dv;
  logic [29:0] v_p;
  logic [15:0] ds;
  logic [30:0] s_p;
  logic [16:0] s_full;
  logic [14:0] s_cl;

  assign zz   = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign sq_p = zz * zz;
  assign t_p  = 27'(zsq1) * 27'd2320;
  assign t2   = t_p[25:14];
  assign dv   = 15'(15'd21024 - {3'd0, t2});
  assign v_p  = dv * zsq2;
  assign ds   = 16'(16'd51472 - v3);
  assign s_p  = ds * z3;
  assign s_full = s_p[30:14];
  assign s_cl = (s_full > 17'd32767) ? 15'h7fff : s_full[14:0];

  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= angle[15:14];
      z0 <= zz;
      zsq1 <= sq_p[28:14];
      q1 <= q0; z1 <= z0;
      zsq2 <= zsq1;
      q2 <= q1; z2r <= z1;
      v3 <= {1'b0, v_p[28:14]};
      q3 <= q2; z3 <= z2r;
      sine <= q3[1] ? -$signed({2'b00, s_cl}) : $signed({2'b00, s_cl});
    end
  end

endmodule

// ===== hdl/ogh_front.sv =====
module ogh_front
  import ogh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] robot_x,
  input  logic signed [COORD_W-1:0] robot_z,
  input  logic [ANGLE_W-1:0]        heading,
  input  logic [9:0]                beam_index,
  input  logic [15:0]               beam_range,
  input  logic                      no_return,
  input  logic signed [15:0]        angle_start,
  input  logic [15:0]               angle_step,
  input  logic [15:0]               min_range,
  input  logic [15:0]               max_range,
  output logic                      q_valid,
  input  logic                      q_ready,
  output beam_t                     q_beam
);

  // Two-entry queue that decouples classification from the grid update.
  beam_t       slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  beam_t       beam;
  logic [25:0] idx_prod;
  logic        push, pop;

  assign idx_prod = beam_index * angle_step;
  always_comb begin
    beam.used = !(no_return || beam_range >= max_range || beam_range < min_range);
    beam.robot_x = robot_x;
    beam.robot_z = robot_z;
    beam.angle = 16'(angle_start + idx_prod[15:0] - heading - 16'd16384);
    beam.beam_range = beam_range;
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_beam = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= beam;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

// ===== hdl/ogh_back.sv =====
module ogh_back
  import ogh_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  beam_t              q_beam,
  input  back_cfg_t          cfg,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [59:0]        out_data
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam logic signed [CW+1:0] HALF = (CW+2)'(GRID_SIDE / 2);
  localparam logic signed [CW+1:0] TOP = (CW+2)'(GRID_SIDE - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SIN   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_PT    = 4'd4;
  localparam logic [3:0] S_GMUL  = 4'd5;
  localparam logic [3:0] S_CELL  = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;
  logic [2:0] wait_cnt;
  logic [AW:0] clr_cnt;
  beam_t cur;

  logic [CONF_W-1:0] conf_mem [CELLS];
  logic              mark_mem [CELLS];

  logic signed [TRIG_W-1:0] sin_v, cos_v;
  logic sin_en;
  logic [ANGLE_W-1:0] cos_ang;

  logic signed [33:0] off_x, off_z;
  logic signed [POINT_W-1:0] px, pz;
  logic signed [28:0] gx_p, gz_p;
  logic [AW-1:0] addr;
  logic [CW-1:0] gx, gy;
  logic [CONF_W-1:0] rd_conf;
  logic rd_mark;
  logic [CONF_W-1:0] conf_new;
  logic fresh;

  assign cos_ang = 16'(cur.angle + 16'd16384);
  assign sin_en = (state == S_SIN);

  ogh_sine u_sin (.clk(clk), .en(sin_en), .angle(cur.angle), .sine(sin_v));
  ogh_sine u_cos (.clk(clk), .en(sin_en), .angle(cos_ang), .sine(cos_v));

  function automatic logic signed [POINT_W-1:0] sat_pt(input logic signed [18:0] v);
    if (v > 19'sd65535) return 17'sd65535;
    if (v < -19'sd65536) return -17'sd65536;
    return v[POINT_W-1:0];
  endfunction

  function automatic logic signed [CW+1:0] trunc12(input logic signed [28:0] p);
    logic [28:0] m;
    logic [16:0] q;
    m = p[28] ? 29'(-p) : 29'(p);
    q = m[28:12];
    return p[28] ? -$signed({1'b0, (CW+1)'(q > 17'(GRID_SIDE) ? 17'(GRID_SIDE) : q)})
                 : $signed({1'b0, (CW+1)'(q > 17'(GRID_SIDE) ? 17'(GRID_SIDE) : q)});
  endfunction

  function automatic logic [CW-1:0] clampc(input logic signed [CW+1:0] v);
    if (v < 0) return '0;
    if (v > TOP) return TOP[CW-1:0];
    return v[CW-1:0];
  endfunction

  logic [CONF_W:0] sum;
  assign sum = {1'b0, rd_conf} + {3'd0, cfg.hit_step};
  always_comb begin
    conf_new = rd_conf;
    if (rd_conf < cfg.confidence_cap) conf_new = sum[CONF_W] ? 8'hff : sum[7:0];
  end
  assign fresh = (conf_new > cfg.occ_limit) && !rd_mark;

  assign q_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE) || q_valid;

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      conf_mem[clr_cnt[AW-1:0]] <= '0;
      mark_mem[clr_cnt[AW-1:0]] <= 1'b0;
    end else if (state == S_UPD) begin
      conf_mem[addr] <= conf_new;
      if (fresh) mark_mem[addr] <= 1'b1;
    end
    if (state == S_READ) begin
      rd_conf <= conf_mem[{gx, gy}];
      rd_mark <= mark_mem[{gx, gy}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      wait_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + (AW+1)'(1);
          if (clr_cnt == (AW+1)'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_beam;
            if (q_beam.used) begin
              state <= S_SIN;
              wait_cnt <= '0;
            end else begin
              out_data <= '0;
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_SIN: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd4) state <= S_MUL;
        end
        S_MUL: begin
          off_x <= $signed({1'b0, cur.beam_range}) * cos_v;
          off_z <= $signed({1'b0, cur.beam_range}) * sin_v;
          state <= S_PT;
        end
        S_PT: begin
          px <= sat_pt(19'(cur.robot_x) + 19'(off_x >>> 15));
          pz <= sat_pt(19'(cur.robot_z) + 19'(off_z >>> 15));
          state <= S_GMUL;
        end
        S_GMUL: begin
          gx_p <= px * $signed({1'b0, cfg.cells_per_meter});
          gz_p <= pz * $signed({1'b0, cfg.cells_per_meter});
          state <= S_CELL;
        end
        S_CELL: begin
          gx <= clampc(trunc12(gx_p) + HALF);
          gy <= clampc(HALF - trunc12(gz_p));
          state <= S_READ;
        end
        S_READ: begin
          addr <= {gx, gy};
          state <= S_UPD;
        end
        S_UPD: begin
          out_data <= {fresh, conf_new, pz, px, 8'(gy), 8'(gx), 1'b1};
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ogh_pkg::*;

  localparam int GRID   = 256;
  localparam int LIMIT  = 3000000;

  // One lidar beam as the stimulus sees it.
  typedef struct {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_z;
    logic [15:0]        heading;
    logic [9:0]         beam_index;
    logic [15:0]        beam_range;
    logic               no_return;
  } lidar_beam_t;

  // One grid update as it leaves the block, most significant field first.
  typedef struct packed {
    logic        newly_occupied;
    logic [7:0]  confidence;
    logic [16:0] point_z;
    logic [16:0] point_x;
    logic [7:0]  cell_y;
    logic [7:0]  cell_x;
    logic        used;
  } grid_hit_t;

  // A row of the directed table; fixed rows carry a result that is obvious
  // by inspection, the others are predicted.
  typedef struct {
    lidar_beam_t beam;
    logic        fixed;
    grid_hit_t   result;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tready;
  logic        m_axis_tvalid;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  occupancy_grid_hit_update_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Shadow copy of the configuration registers.
  logic signed [15:0] start_angle_q;
  logic [15:0]        step_angle_q;
  logic [15:0]        range_lo_q;
  logic [15:0]        range_hi_q;
  logic [9:0]         cells_per_m_q;
  logic [5:0]         hit_inc_q;
  logic [7:0]         occ_thresh_q;
  logic [7:0]         conf_cap_q;

  // Shadow copy of the cell confidences and occupied marks.
  logic [7:0] cell_conf [GRID*GRID];
  logic       cell_marked [GRID*GRID];

  grid_hit_t pending_hits[$];
  int        mismatches;
  int        hits_seen;
  bit        senders_gaps;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Q1.15 sine of a 16-bit turn fraction, polynomial over one quarter turn.
  function automatic longint sine_q15(logic [15:0] a);
    longint quad, frac, z, z2, t, v, s;
    quad = a[15:14];
    frac = a[13:0];
    z    = quad[0] ? 16384 - frac : frac;
    z2   = (z * z) >>> 14;
    t    = (2320 * z2) >>> 14;
    v    = ((21024 - t) * z2) >>> 14;
    s    = ((51472 - v) * z) >>> 14;
    if (s > 32767) s = 32767;
    return (quad >= 2) ? -s : s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Division by 4096 rounding toward zero.
  function automatic longint cell_offset(longint p);
    return p >= 0 ? (p >>> 12) : -((-p) >>> 12);
  endfunction

  // Works out the grid update for one beam and advances the shadow grid.
  function automatic grid_hit_t project_beam(lidar_beam_t b);
    grid_hit_t r;
    logic [15:0] ang;
    longint px, pz, gx, gy, conf;
    int cell_idx;
    r = '0;
    if (b.no_return || b.beam_range >= range_hi_q || b.beam_range < range_lo_q) return r;
    ang = 16'(longint'(start_angle_q) + longint'(b.beam_index) * longint'(step_angle_q)
              - longint'(b.heading) - 16384);
    // The arithmetic shift of a signed product floors toward minus infinity.
    px = longint'(b.robot_x) + ((longint'(b.beam_range) * sine_q15(ang + 16'd16384)) >>> 15);
    pz = longint'(b.robot_z) + ((longint'(b.beam_range) * sine_q15(ang)) >>> 15);
    px = clamp(px, -65536, 65535);
    pz = clamp(pz, -65536, 65535);
    gx = clamp(cell_offset(px * longint'(cells_per_m_q)) + GRID / 2, 0, GRID - 1);
    gy = clamp(GRID / 2 - cell_offset(pz * longint'(cells_per_m_q)), 0, GRID - 1);
    cell_idx = int'(gx) * GRID + int'(gy);
    conf = cell_conf[cell_idx];
    if (conf < conf_cap_q) begin
      conf = clamp(conf + hit_inc_q, 0, 255);
      cell_conf[cell_idx] = 8'(conf);
    end
    r.used = 1'b1;
    if (conf > occ_thresh_q && !cell_marked[cell_idx]) begin
      cell_marked[cell_idx] = 1'b1;
      r.newly_occupied = 1'b1;
    end
    r.cell_x     = 8'(gx);
    r.cell_y     = 8'(gy);
    r.point_x    = 17'(px);
    r.point_z    = 17'(pz);
    r.confidence = 8'(conf);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ANGLE_START: start_angle_q = value;
      REG_ANGLE_STEP:  step_angle_q  = value;
      REG_MIN_RANGE:   range_lo_q    = value;
      REG_MAX_RANGE:   range_hi_q    = value;
      REG_CELLS_PER_M: cells_per_m_q = value[9:0];
      REG_HIT_INC:     hit_inc_q     = value[5:0];
      REG_OCC_THRESH:  occ_thresh_q  = value[7:0];
      REG_CONF_CAP:    conf_cap_q    = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                           logic [15:0] a3, logic [15:0] a4, logic [15:0] a5,
                           logic [15:0] a6, logic [15:0] a7);
    write_reg(REG_ANGLE_START, a0);
    write_reg(REG_ANGLE_STEP,  a1);
    write_reg(REG_MIN_RANGE,   a2);
    write_reg(REG_MAX_RANGE,   a3);
    write_reg(REG_CELLS_PER_M, a4);
    write_reg(REG_HIT_INC,     a5);
    write_reg(REG_OCC_THRESH,  a6);
    write_reg(REG_CONF_CAP,    a7);
  endtask

  // Offers one beam, after a random gap when senders_gaps is set, and records
  // what it must produce. Valid stays high between back-to-back beams.
  task automatic send_beam(lidar_beam_t b, logic fixed, grid_hit_t fixed_hit);
    grid_hit_t predicted;
    int gap;
    gap = senders_gaps ? gap_cycles() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, b.no_return, b.beam_range, b.beam_index,
                     b.heading, b.robot_z, b.robot_x};
    do @(posedge clk); while (!s_axis_tready);
    predicted = project_beam(b);
    pending_hits.push_back(fixed ? fixed_hit : predicted);
    @(negedge clk);
  endtask

  // Waits until every result is back and the block has settled.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    @(negedge clk);
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Well-formed beams land inside the accepted range window, half with poses
  // near the origin so that cells are hit again and again; the rest is noise.
  function automatic lidar_beam_t random_beam();
    lidar_beam_t b;
    b.robot_x    = 16'($urandom);
    b.robot_z    = 16'($urandom);
    b.heading    = 16'($urandom);
    b.beam_index = 10'($urandom);
    b.beam_range = 16'($urandom);
    b.no_return  = 1'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      b.no_return = 1'b0;
      if ($urandom_range(0, 1)) begin
        b.robot_x = 16'($signed($urandom_range(0, 2047)) - 1024);
        b.robot_z = 16'($signed($urandom_range(0, 2047)) - 1024);
      end
      if (range_hi_q > range_lo_q)
        b.beam_range = 16'($urandom_range(range_lo_q, range_hi_q - 1));
    end
    return b;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) senders_gaps = ($urandom_range(0, 3) != 0);
      send_beam(random_beam(), 1'b0, '0);
    end
    senders_gaps = 1'b1;
    drain();
  endtask

  // Result side: random stalls, one long hold-off once results are flowing so
  // that the output register and the input queue fill up.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && hits_seen >= 30) begin
        held = 1'b1;
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk);
      end
      stall = gap_cycles();
      m_axis_tready = (stall == 0);
      if (stall > 0) repeat (stall - 1) @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    grid_hit_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[59:0];
      hits_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_hits.pop_front();
        if (got.used !== want.used || got.cell_x !== want.cell_x ||
            got.cell_y !== want.cell_y || got.point_x !== want.point_x ||
            got.point_z !== want.point_z || got.confidence !== want.confidence ||
            got.newly_occupied !== want.newly_occupied) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected used=%b cell=(%0d,%0d) point=(%h,%h) ",
                      "conf=%0d new=%b, got used=%b cell=(%0d,%0d) point=(%h,%h) ",
                      "conf=%0d new=%b"},
                     hits_seen, want.used, want.cell_x, want.cell_y, want.point_x,
                     want.point_z, want.confidence, want.newly_occupied, got.used,
                     got.cell_x, got.cell_y, got.point_x, got.point_z,
                     got.confidence, got.newly_occupied);
        end
      end
    end
  end

  // Watchdog; the limit covers the store clearing pass after reset as well.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    lidar_beam_t b;
    grid_hit_t skipped, centre;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mismatches = 0;
    hits_seen  = 0;
    senders_gaps = 1'b1;
    start_angle_q = -16'sd16384;
    step_angle_q  = 16'd128;
    range_lo_q    = 16'd0;
    range_hi_q    = 16'hFFFF;
    cells_per_m_q = 10'd100;
    hit_inc_q     = 6'd5;
    occ_thresh_q  = 8'd20;
    conf_cap_q    = 8'd100;
    for (int i = 0; i < GRID * GRID; i++) begin
      cell_conf[i]   = '0;
      cell_marked[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset configuration. A zero range from the origin
    // lands on the centre cell; the fifth hit takes it past the default
    // threshold.
    skipped = '0;
    centre = '0;
    centre.used = 1'b1;
    centre.cell_x = 8'd128;
    centre.cell_y = 8'd128;
    b = '{16'sd0, 16'sd0, 16'd0, 10'd0, 16'd0, 1'b0};
    for (int k = 1; k <= 5; k++) begin
      centre.confidence = 8'(5 * k);
      centre.newly_occupied = (k == 5);
      rows.push_back('{b, 1'b1, centre});
    end
    // No return skips the beam whatever the range.
    rows.push_back('{'{16'sd0, 16'sd0, 16'd0, 10'd0, 16'd1000, 1'b1}, 1'b1, skipped});
    rows.push_back('{'{16'h7FFF, 16'h8000, 16'hFFFF, 10'h3FF, 16'hFFFE, 1'b1}, 1'b1,
                     skipped});
    // A range equal to the maximum is outside the window.
    rows.push_back('{'{16'sd0, 16'sd0, 16'd0, 10'd0, 16'hFFFF, 1'b0}, 1'b1, skipped});
    // Pose and range extremes; points saturate and cells clamp.
    rows.push_back('{'{16'h7FFF, 16'h7FFF, 16'd0, 10'd0, 16'hFFFE, 1'b0}, 1'b0, '0});
    rows.push_back('{'{16'h8000, 16'h8000, 16'd32768, 10'd0, 16'hFFFE, 1'b0}, 1'b0, '0});
    rows.push_back('{'{16'h7FFF, 16'h8000, 16'hFFFF, 10'h3FF, 16'hFFFE, 1'b0}, 1'b0, '0});
    rows.push_back('{'{16'h8000, 16'h7FFF, 16'd16384, 10'h200, 16'h8000, 1'b0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'd49152, 10'd128, 16'd4096, 1'b0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'd0, 10'd255, 16'd40960, 1'b0}, 1'b0, '0});
    rows.push_back('{'{16'sd4096, -16'sd4096, 16'd8192, 10'd64, 16'd1, 1'b0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'd0, 10'd0, 16'd1, 1'b0}, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_beam(row.beam, row.fixed, row.result);
    end
    drain();

    random_phase(300);

    // Coarse grid with saturating confidence: many repeats per cell.
    write_all(16'hC000, 16'd128, 16'd0, 16'hFFFF, 16'd1, 16'd63, 16'd255, 16'd255);
    random_phase(300);

    // Zero scale: every hit goes to the centre cell.
    write_all(16'd0, 16'd1, 16'd1, 16'd65000, 16'd0, 16'd7, 16'd100, 16'd192);
    random_phase(300);

    // Angle and scale extremes with a narrow range window.
    write_all(16'h8000, 16'hFFFF, 16'd4096, 16'd40000, 16'd1023, 16'd0, 16'd0, 16'd192);
    random_phase(300);

    write_all(16'h7FFF, 16'd0, 16'd100, 16'hFFFF, 16'd10, 16'd33, 16'd50, 16'd150);
    random_phase(300);

    write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
              16'($urandom_range(30000, 65535)), 16'($urandom_range(1, 60)),
              16'($urandom_range(0, 63)), 16'($urandom_range(0, 255)),
              16'($urandom_range(0, 192)));
    random_phase(330);

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ogh_pkg.sv
hdl/ogh_sine.sv
hdl/ogh_front.sv
hdl/ogh_back.sv
hdl/occupancy_grid_hit_update_unit.sv
sim/testbench.sv
